// ===== rtl/stmr_pkg.sv =====
// shared types, codes and the divider step for the tile-map background renderer
// used by stmr_div, stmr_mem and scrolled_tile_map_pixel_renderer
package stmr_pkg;

    typedef logic [1:0] op_t;
    localparam op_t OP_TILE    = 2'd0;
    localparam op_t OP_PALETTE = 2'd1;
    localparam op_t OP_RENDER  = 2'd2;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SCROLL_HORIZ = 3'd0;
    localparam cfg_idx_t CFG_SCROLL_VERT  = 3'd1;
    localparam cfg_idx_t CFG_TILE_PIXELS  = 3'd2;
    localparam cfg_idx_t CFG_MAP_COLS     = 3'd3;
    localparam cfg_idx_t CFG_MAP_ROWS     = 3'd4;
    localparam cfg_idx_t CFG_MAP_READY    = 3'd5;

    localparam int DVD_W = 16;  // world coordinate, non-negative part
    localparam int TS_W  = 7;   // tile edge and its remainder
    localparam int ACC_W = TS_W + DVD_W;

    typedef logic [ACC_W-1:0] acc_t;

    // everything an item carries down the pipeline
    typedef struct packed {
        op_t        op;
        logic       emit;
        logic       zero;
        logic [6:0] ts;
        logic [6:0] cols;
        logic [6:0] rows;
        logic [5:0] tile_col;
        logic [5:0] tile_row;
        logic [7:0] tile_code;
        logic [7:0] palette_slot;
        logic [7:0] palette_color;
    } tag_t;

    // one restoring division step: {remainder, dividend/quotient} shifted left
    function automatic acc_t div_step(acc_t acc, logic [TS_W-1:0] ts);
        logic [TS_W:0]   cand;
        logic [TS_W:0]   diff;
        logic            q;
        logic [TS_W-1:0] rem;
        cand = acc[ACC_W-1:DVD_W-1];
        diff = cand - {1'b0, ts};
        q    = (cand >= {1'b0, ts});
        rem  = q ? diff[TS_W-1:0] : cand[TS_W-1:0];
        return {rem, acc[DVD_W-2:0], q};
    endfunction

endpackage

// ===== rtl/stmr_div.sv =====
// pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage
// depends on stmr_pkg (tag_t, acc_t, div_step)
module stmr_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  stmr_pkg::tag_t              in_tag,
    input  logic [stmr_pkg::DVD_W-1:0]  in_dvd_x,
    input  logic [stmr_pkg::DVD_W-1:0]  in_dvd_y,
    output logic                        out_valid,
    output stmr_pkg::tag_t              out_tag,
    output logic [stmr_pkg::DVD_W-1:0]  out_quot_x,
    output logic [stmr_pkg::DVD_W-1:0]  out_quot_y
);

    localparam int N = stmr_pkg::DVD_W;

    logic [N-1:0]   valid_reg;
    stmr_pkg::tag_t tag_reg  [N];
    stmr_pkg::acc_t accx_reg [N];
    stmr_pkg::acc_t accy_reg [N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[N-2:0], in_valid};
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                tag_reg[0]  <= in_tag;
                accx_reg[0] <= stmr_pkg::div_step({7'd0, in_dvd_x}, in_tag.ts);
                accy_reg[0] <= stmr_pkg::div_step({7'd0, in_dvd_y}, in_tag.ts);
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk)
            begin
                tag_reg[i]  <= tag_reg[i-1];
                accx_reg[i] <= stmr_pkg::div_step(accx_reg[i-1], tag_reg[i-1].ts);
                accy_reg[i] <= stmr_pkg::div_step(accy_reg[i-1], tag_reg[i-1].ts);
            end
        end
    end

    assign out_valid  = valid_reg[N-1];
    assign out_tag    = tag_reg[N-1];
    assign out_quot_x = accx_reg[N-1][N-1:0];
    assign out_quot_y = accy_reg[N-1][N-1:0];

endmodule

// ===== rtl/stmr_mem.sv =====
// tile store and palette store with their read and write stages and the clearing pass
// depends on stmr_pkg (tag_t, op codes)
module stmr_mem #(
    parameter int MAP_MAX_COLS = 64,
    parameter int MAP_MAX_ROWS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  stmr_pkg::tag_t              in_tag,
    input  logic [stmr_pkg::DVD_W-1:0]  in_quot_x,
    input  logic [stmr_pkg::DVD_W-1:0]  in_quot_y,
    output logic                        clearing,
    output logic                        done,
    output logic [7:0]                  pixel_color
);

    localparam int TILES   = MAP_MAX_COLS * MAP_MAX_ROWS;
    localparam int TILE_AW = (TILES > 1) ? $clog2(TILES) : 1;
    localparam int CLR_LEN = (TILES > 256) ? TILES : 256;
    localparam int CLR_W   = $clog2(CLR_LEN);

    logic [7:0] tile_mem [TILES];
    logic [7:0] pal_mem  [256];

    // clearing pass after reset
    logic             clr_active_reg;
    logic             clr_active_next;
    logic [CLR_W-1:0] clr_cnt_reg;
    logic [CLR_W-1:0] clr_cnt_next;
    logic             clr_tile_en;
    logic             clr_pal_en;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_cnt_next    = clr_cnt_reg;
        if (clr_active_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_W'(CLR_LEN - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    assign clr_tile_en = clr_active_reg && ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(TILES));
    assign clr_pal_en  = clr_active_reg && ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(256));

    // tile stage
    logic               t_wr;
    logic [TILE_AW-1:0] t_addr;
    logic               t_in_map;
    logic               t_wr_ok;

    assign t_wr_ok = ({3'b0, in_tag.tile_col} < 9'(MAP_MAX_COLS))
                  && ({3'b0, in_tag.tile_row} < 9'(MAP_MAX_ROWS));
    assign t_wr    = in_valid && (in_tag.op == stmr_pkg::OP_TILE) && t_wr_ok;

    assign t_in_map = !in_tag.zero
                   && ({1'b0, in_quot_x} < 17'(MAP_MAX_COLS))
                   && ({1'b0, in_quot_y} < 17'(MAP_MAX_ROWS))
                   && (in_quot_x < {9'd0, in_tag.cols})
                   && (in_quot_y < {9'd0, in_tag.rows});

    always_comb
    begin
        if (in_tag.op == stmr_pkg::OP_TILE)
        begin
            t_addr = TILE_AW'(in_tag.tile_row) * TILE_AW'(MAP_MAX_COLS)
                   + TILE_AW'(in_tag.tile_col);
        end
        else
        begin
            t_addr = TILE_AW'(in_quot_y) * TILE_AW'(MAP_MAX_COLS) + TILE_AW'(in_quot_x);
        end
    end

    logic [7:0] tile_rd_reg;

    always_ff @(posedge clk)
    begin
        if (clr_tile_en)
        begin
            tile_mem[clr_cnt_reg[TILE_AW-1:0]] <= 8'd0;
        end
        else if (t_wr)
        begin
            tile_mem[t_addr] <= in_tag.tile_code;
        end
        tile_rd_reg <= tile_mem[t_addr];
    end

    // palette stage
    logic           p_valid_reg;
    stmr_pkg::tag_t p_tag_reg;
    logic           p_in_map_reg;
    logic           palette_on_reg;
    logic           palette_on_next;
    logic           p_wr;
    logic [7:0]     p_addr;
    logic [7:0]     pal_rd_reg;

    assign p_wr   = p_valid_reg && (p_tag_reg.op == stmr_pkg::OP_PALETTE);
    assign p_addr = p_wr ? p_tag_reg.palette_slot : tile_rd_reg;
    assign palette_on_next = palette_on_reg || p_wr;

    always_ff @(posedge clk)
    begin
        if (clr_pal_en)
        begin
            pal_mem[clr_cnt_reg[7:0]] <= 8'd0;
        end
        else if (p_wr)
        begin
            pal_mem[p_addr] <= p_tag_reg.palette_color;
        end
        pal_rd_reg <= pal_mem[p_addr];
    end

    // color stage
    logic       q_valid_reg;
    logic [7:0] q_code_reg;
    logic       q_black_reg;
    logic       q_pal_on_reg;
    logic       done_reg;
    logic [7:0] color_reg;
    logic [7:0] color_next;

    always_comb
    begin
        if (q_black_reg)
        begin
            color_next = 8'd0;
        end
        else if (q_pal_on_reg)
        begin
            color_next = pal_rd_reg;
        end
        else
        begin
            color_next = q_code_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            p_valid_reg    <= 1'b0;
            q_valid_reg    <= 1'b0;
            done_reg       <= 1'b0;
            palette_on_reg <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_cnt_reg    <= clr_cnt_next;
            p_valid_reg    <= in_valid;
            q_valid_reg    <= p_valid_reg && p_tag_reg.emit;
            done_reg       <= q_valid_reg;
            palette_on_reg <= palette_on_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_tag_reg    <= in_tag;
        p_in_map_reg <= t_in_map;
        q_code_reg   <= tile_rd_reg;
        q_black_reg  <= !p_in_map_reg || (tile_rd_reg == 8'd0);
        q_pal_on_reg <= palette_on_reg;
        color_reg    <= color_next;
    end

    assign clearing    = clr_active_reg;
    assign done        = done_reg;
    assign pixel_color = color_reg;

endmodule

// ===== rtl/scrolled_tile_map_pixel_renderer.sv =====
// top level of the scrolled tile-map background renderer: configuration, accept stage
// depends on stmr_pkg, stmr_div and stmr_mem
//
// One item is taken per clock while busy is low; tile writes, palette writes and pixel
// requests all flow through one in-order pipeline, so a pixel sees exactly the writes taken
// before it. A pixel result appears on done / pixel_color 19 cycles after its item is taken
// (16 divider stages for the tile index, one tile store read, one palette read, one output
// register), and must be taken in that cycle since there is no stall. After reset busy
// stays high for max(MAP_MAX_COLS * MAP_MAX_ROWS, 256) cycles while both stores are
// cleared; configuration writes are taken at any time and cfg_ready is always high.
module scrolled_tile_map_pixel_renderer #(
    parameter int MAP_MAX_COLS  = 64,
    parameter int MAP_MAX_ROWS  = 64,
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [5:0]  tile_col,
    input  logic [5:0]  tile_row,
    input  logic [7:0]  tile_code,
    input  logic [7:0]  palette_slot,
    input  logic [7:0]  palette_color,
    input  logic [8:0]  pixel_x,
    input  logic [7:0]  pixel_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        done,
    output logic [7:0]  pixel_color
);

    localparam int LATENCY = stmr_pkg::DVD_W + 3;

    logic [15:0] scroll_horiz_reg;
    logic [15:0] scroll_vert_reg;
    logic [6:0]  tile_pixels_reg;
    logic [6:0]  map_cols_reg;
    logic [6:0]  map_rows_reg;
    logic        map_ready_reg;
    logic        cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_horiz_reg <= 16'd0;
            scroll_vert_reg  <= 16'd0;
            tile_pixels_reg  <= 7'd16;
            map_cols_reg     <= 7'd0;
            map_rows_reg     <= 7'd0;
            map_ready_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                stmr_pkg::CFG_SCROLL_HORIZ: scroll_horiz_reg <= cfg_data;
                stmr_pkg::CFG_SCROLL_VERT:  scroll_vert_reg  <= cfg_data;
                stmr_pkg::CFG_TILE_PIXELS:  tile_pixels_reg  <= cfg_data[6:0];
                stmr_pkg::CFG_MAP_COLS:     map_cols_reg     <= cfg_data[6:0];
                stmr_pkg::CFG_MAP_ROWS:     map_rows_reg     <= cfg_data[6:0];
                stmr_pkg::CFG_MAP_READY:    map_ready_reg    <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // accept stage: world position and item tag
    logic               accept;
    logic               clearing;
    logic signed [16:0] world_x;
    logic signed [16:0] world_y;
    logic               off_screen;
    stmr_pkg::tag_t     tag;

    assign busy   = clearing;
    assign accept = start && !busy;

    assign world_x = $signed({8'd0, pixel_x}) + $signed({scroll_horiz_reg[15], scroll_horiz_reg});
    assign world_y = $signed({9'd0, pixel_y}) + $signed({scroll_vert_reg[15], scroll_vert_reg});

    assign off_screen = ({4'd0, pixel_x} >= 13'(SCREEN_WIDTH))
                     || ({5'd0, pixel_y} >= 13'(SCREEN_HEIGHT));

    always_comb
    begin
        tag.op            = op;
        tag.emit          = (op == stmr_pkg::OP_RENDER) && map_ready_reg;
        tag.zero          = off_screen || world_x[16] || world_y[16];
        tag.ts            = (tile_pixels_reg == 7'd0) ? 7'd1 : tile_pixels_reg;
        tag.cols          = map_cols_reg;
        tag.rows          = map_rows_reg;
        tag.tile_col      = tile_col;
        tag.tile_row      = tile_row;
        tag.tile_code     = tile_code;
        tag.palette_slot  = palette_slot;
        tag.palette_color = palette_color;
    end

    logic                       d_valid;
    stmr_pkg::tag_t             d_tag;
    logic [stmr_pkg::DVD_W-1:0] d_quot_x;
    logic [stmr_pkg::DVD_W-1:0] d_quot_y;

    stmr_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_tag     (tag),
        .in_dvd_x   (world_x[15:0]),
        .in_dvd_y   (world_y[15:0]),
        .out_valid  (d_valid),
        .out_tag    (d_tag),
        .out_quot_x (d_quot_x),
        .out_quot_y (d_quot_y)
    );

    stmr_mem #(
        .MAP_MAX_COLS (MAP_MAX_COLS),
        .MAP_MAX_ROWS (MAP_MAX_ROWS)
    ) u_mem (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (d_valid),
        .in_tag      (d_tag),
        .in_quot_x   (d_quot_x),
        .in_quot_y   (d_quot_y),
        .clearing    (clearing),
        .done        (done),
        .pixel_color (pixel_color)
    );

`ifndef SYNTHESIS
    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe during clearing pass");

    a_clear_runs_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy returned after clearing pass ended");

    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept && (op == stmr_pkg::OP_RENDER) && map_ready_reg, LATENCY))
        else $error("result without a render item taken at the pipeline latency");
`endif

endmodule
